### hw/rtl/pdr_pkg.sv
// Shared types, constants and the CORDIC angle table for the pose integrator.
// No dependencies; every other RTL file imports this package.
package pdr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_ITERS = 16;
  localparam int ANG_FRAC     = 24;
  localparam int TRIG_FRAC    = 30;
  localparam int DT_FRAC      = 16;

  localparam int POS_W  = 32;
  localparam int HEAD_W = 25;
  localparam int DT_W   = 16;
  localparam int MUL_W  = 33;             // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int WRAP_W = 34;             // signed heading before reduction
  localparam int CW     = 33;             // CORDIC x/y, Q2.30
  localparam int ZW     = 34;             // CORDIC angle, degrees Q.24
  localparam int ITER_W = $clog2(CORDIC_ITERS);
  localparam int TBL_W  = 5;

  localparam int WRAP_STEPS = 8;          // conditional subtracts of 360 << k
  localparam int WRAP_K_W   = $clog2(WRAP_STEPS);

  localparam logic [HEAD_W-1:0] HEAD_MOD = HEAD_W'(360 << FRAC_BITS);
  localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);
  localparam logic [DT_W-1:0] TIME_STEP_RESET = DT_W'(655);

  // word kind carried on s_tuser
  typedef enum logic {OP_DRIVE = 1'b0, OP_TELEPORT = 1'b1} word_op_t;

  typedef struct packed {
    logic                     start;
    logic signed [WRAP_W-1:0] value;
  } wrap_req_t;

  typedef struct packed {
    logic              done;
    logic [HEAD_W-1:0] heading;
  } wrap_rsp_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
  } trig_rsp_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [31:0] atan_deg(input logic [TBL_W-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:    r = 32'sd754974720;
      5'd1:    r = 32'sd445687602;
      5'd2:    r = 32'sd235489088;
      5'd3:    r = 32'sd119537938;
      5'd4:    r = 32'sd60000934;
      5'd5:    r = 32'sd30029717;
      5'd6:    r = 32'sd15018523;
      5'd7:    r = 32'sd7509720;
      5'd8:    r = 32'sd3754917;
      5'd9:    r = 32'sd1877466;
      5'd10:   r = 32'sd938734;
      5'd11:   r = 32'sd469367;
      5'd12:   r = 32'sd234684;
      5'd13:   r = 32'sd117342;
      5'd14:   r = 32'sd58671;
      5'd15:   r = 32'sd29335;
      5'd16:   r = 32'sd14668;
      5'd17:   r = 32'sd7334;
      5'd18:   r = 32'sd3667;
      5'd19:   r = 32'sd1833;
      5'd20:   r = 32'sd917;
      5'd21:   r = 32'sd458;
      5'd22:   r = 32'sd229;
      5'd23:   r = 32'sd115;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/pdr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pdr_pkg for operand and product widths.
module pdr_mul import pdr_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hw/rtl/pdr_wrap.sv
// Iterative reduction of a signed heading modulo 360 degrees into [0,360).
// One compare-and-subtract per cycle; depends on pdr_pkg.
module pdr_wrap import pdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  wrap_req_t req,
  output wrap_rsp_t rsp
);

  localparam int RW = WRAP_W - 1;
  localparam logic signed [WRAP_W-1:0] LIFT = WRAP_W'(HEAD_MOD) << (WRAP_STEPS - 1);

  logic [RW-1:0]       r;
  logic [WRAP_K_W-1:0] k;
  logic                busy;
  logic                done;
  logic [RW-1:0]       m_k;
  logic signed [WRAP_W-1:0] lifted;

  assign m_k    = RW'(HEAD_MOD) << k;
  assign lifted = req.value + LIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        k    <= WRAP_K_W'(WRAP_STEPS - 1);
        // lift negatives by 360 * 2^(steps-1) so the value starts non-negative
        if (req.value[WRAP_W-1]) begin
          r <= lifted[RW-1:0];
        end else begin
          r <= req.value[RW-1:0];
        end
      end else if (busy) begin
        if (r >= m_k) begin
          r <= r - m_k;
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.heading = r[HEAD_W-1:0];

endmodule

### hw/rtl/pdr_cordic.sv
// Rotation-mode CORDIC in degrees: cos and sin of a heading, Q2.30 results.
// One x/y/z micro-rotation per cycle; depends on pdr_pkg for the angle table.
module pdr_cordic import pdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HEAD_W-1:0] heading,
  output trig_rsp_t         rsp
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_FOLD = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  localparam logic signed [ZW-1:0] Z_FULL    = ZW'(longint'(360) << ANG_FRAC);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(longint'(180) << ANG_FRAC);
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(longint'(90) << ANG_FRAC);

  logic [1:0]           state;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic                 flip;
  logic [ITER_W-1:0]    i;
  logic                 done;
  logic signed [CW-1:0] cos_v;
  logic signed [CW-1:0] sin_v;

  logic signed [ZW-1:0] z0;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang;

  assign z0  = ZW'(heading) << (ANG_FRAC - FRAC_BITS);
  assign xs  = x >>> i;
  assign ys  = y >>> i;
  assign ang = ZW'(atan_deg(TBL_W'(i)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            z     <= (z0 > Z_HALF) ? z0 - Z_FULL : z0;
            state <= C_FOLD;
          end
        end
        C_FOLD: begin
          // fold into [-90,90]; a half-turn fold negates the results
          if (z > Z_QUARTER) begin
            z    <= z - Z_HALF;
            flip <= 1'b1;
          end else if (z < -Z_QUARTER) begin
            z    <= z + Z_HALF;
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
          x     <= CORDIC_START;
          y     <= '0;
          i     <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[ZW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end
          if (i == ITER_W'(CORDIC_ITERS - 1)) begin
            state <= C_FIN;
          end else begin
            i <= i + 1'b1;
          end
        end
        C_FIN: begin
          cos_v <= flip ? -x : x;
          sin_v <= flip ? -y : y;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = cos_v;
  assign rsp.sin_v = sin_v;

endmodule

### hw/rtl/pose_dead_reckoning_integrator_unit.sv
// Planar pose integrator (unicycle dead reckoning) with a small sequencer.
// A drive word runs heading accumulation and reduction, the CORDIC, then two multiply
// passes (x, then y) on the shared multiplier; a teleport word runs the heading
// reduction only. One word in flight: s_tready is high only in the idle state, and a
// full output register waiting on m_tready holds the sequencer before it returns there.
// Reset (rst, synchronous, active high) clears the pose, sets time_step to 655.
module pose_dead_reckoning_integrator_unit import pdr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // lin_vel[31:0], ang_vel[63:32], set_x[95:64], set_y[127:96], set_heading[159:128]
  input  logic [159:0]    s_tdata,
  // op[0]
  input  logic            s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  // pos_x[31:0], pos_y[63:32], pose_heading[88:64], zero[95:89]
  output logic [95:0]     m_tdata,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [DT_W-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HMUL = 4'd1;
  localparam logic [3:0] ST_HADD = 4'd2;
  localparam logic [3:0] ST_TSET = 4'd3;
  localparam logic [3:0] ST_WRAP = 4'd4;
  localparam logic [3:0] ST_TRIG = 4'd5;
  localparam logic [3:0] ST_VMUL = 4'd6;
  localparam logic [3:0] ST_VRND = 4'd7;
  localparam logic [3:0] ST_DMUL = 4'd8;
  localparam logic [3:0] ST_PADD = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam int CHG_W = PROD_W - DT_FRAC;
  localparam int V_W   = MUL_W;
  localparam int D_W   = 34;
  localparam int SUM_W = D_W + 1;

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

  logic [3:0]              state;
  logic [DT_W-1:0]         time_step;
  logic                    op;
  logic signed [POS_W-1:0] lin;
  logic signed [POS_W-1:0] ang;
  logic signed [POS_W-1:0] set_hd;
  logic signed [POS_W-1:0] x_position;
  logic signed [POS_W-1:0] y_position;
  logic [HEAD_W-1:0]       heading_angle;
  logic signed [CW-1:0]    trig_c;
  logic signed [CW-1:0]    trig_s;
  logic signed [V_W-1:0]   v;
  logic                    axis;          // 0: x pass, 1: y pass
  logic [95:0]             out_word;
  logic                    out_valid;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  wrap_req_t                wreq;
  wrap_rsp_t                wrsp;
  trig_rsp_t                trsp;
  logic                     trig_start;

  logic signed [PROD_W-1:0] rnd16;
  logic signed [PROD_W-1:0] rnd30;
  logic signed [WRAP_W-1:0] head_sum;
  logic signed [D_W-1:0]    d;
  logic signed [SUM_W-1:0]  pos_sum;
  logic signed [POS_W-1:0]  pos_cur;
  logic signed [POS_W-1:0]  pos_new;
  logic signed [MUL_W-1:0]  dt_s;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_word;

  assign dt_s = $signed({{(MUL_W - DT_W){1'b0}}, time_step});

  // multiplier operand select
  always_comb begin
    case (state)
      ST_HMUL: begin
        mul_a = MUL_W'(ang);
        mul_b = dt_s;
      end
      ST_VMUL: begin
        mul_a = MUL_W'(lin);
        mul_b = axis ? MUL_W'(trig_s) : MUL_W'(trig_c);
      end
      default: begin
        mul_a = v;
        mul_b = dt_s;
      end
    endcase
  end

  pdr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // round half up on the dropped bits
  assign rnd16    = (prod + (PROD_W'(1) << (DT_FRAC - 1))) >>> DT_FRAC;
  assign rnd30    = (prod + (PROD_W'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
  assign head_sum = $signed({{(WRAP_W - HEAD_W){1'b0}}, heading_angle})
                    + WRAP_W'(rnd16[CHG_W-1:0]);
  assign d        = rnd16[D_W-1:0];

  assign wreq.start = (state == ST_HADD) || (state == ST_TSET);
  assign wreq.value = (state == ST_TSET) ? WRAP_W'(set_hd) : head_sum;

  pdr_wrap u_wrap (
    .clk (clk),
    .rst (rst),
    .req (wreq),
    .rsp (wrsp)
  );

  assign trig_start = (state == ST_WRAP) && wrsp.done && (op != OP_TELEPORT);

  pdr_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .heading (wrsp.heading),
    .rsp     (trsp)
  );

  assign pos_cur = axis ? y_position : x_position;
  assign pos_sum = SUM_W'(pos_cur) + SUM_W'(d);

  always_comb begin
    if (pos_sum > POS_MAX) begin
      pos_new = POS_MAX[POS_W-1:0];
    end else if (pos_sum < POS_MIN) begin
      pos_new = POS_MIN[POS_W-1:0];
    end else begin
      pos_new = pos_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      time_step     <= TIME_STEP_RESET;
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        time_step <= cfg_data;
      end
      // ST_OUT reloads the output register itself
      if (out_valid && m_tready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            lin    <= s_tdata[31:0];
            ang    <= s_tdata[63:32];
            set_hd <= s_tdata[159:128];
            if (s_tuser == OP_TELEPORT) begin
              x_position <= s_tdata[95:64];
              y_position <= s_tdata[127:96];
              state      <= ST_TSET;
            end else begin
              state <= ST_HMUL;
            end
          end
        end
        ST_HMUL: state <= ST_HADD;
        ST_HADD: state <= ST_WRAP;
        ST_TSET: state <= ST_WRAP;
        ST_WRAP: begin
          if (wrsp.done) begin
            heading_angle <= wrsp.heading;
            state         <= (op == OP_TELEPORT) ? ST_OUT : ST_TRIG;
          end
        end
        ST_TRIG: begin
          if (trsp.done) begin
            trig_c <= trsp.cos_v;
            trig_s <= trsp.sin_v;
            axis   <= 1'b0;
            state  <= ST_VMUL;
          end
        end
        ST_VMUL: state <= ST_VRND;
        ST_VRND: begin
          v     <= rnd30[V_W-1:0];
          state <= ST_DMUL;
        end
        ST_DMUL: state <= ST_PADD;
        ST_PADD: begin
          if (axis) begin
            y_position <= pos_new;
            state      <= ST_OUT;
          end else begin
            x_position <= pos_new;
            axis       <= 1'b1;
            state      <= ST_VMUL;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_word  <= {7'b0, heading_angle, y_position, x_position};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/pose_dead_reckoning_integrator_unit_test.sv
// Self-checking bench for the pose dead-reckoning integrator: stream words in,
// pose words out, compared against a bit-accurate CORDIC/fixed-point predictor.
// Depends on pdr_pkg and pose_dead_reckoning_integrator_unit only.
module pose_dead_reckoning_integrator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdr_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       heading;
  } pose_t;

  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MISMATCH_SHOWN = 10;
  localparam int RAND_PHASES    = 5;
  localparam int RAND_PER_PHASE = 80;

  localparam logic signed [31:0] S32_MAX  = 32'h7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'h8000_0000;
  localparam logic signed [31:0] DEG_45   = 32'sd45 <<< FRAC_BITS;
  localparam logic signed [31:0] DEG_90   = 32'sd90 <<< FRAC_BITS;
  localparam logic signed [31:0] DEG_180  = 32'sd180 <<< FRAC_BITS;
  localparam logic signed [31:0] DEG_270  = 32'sd270 <<< FRAC_BITS;
  localparam logic signed [31:0] DEG_360  = 32'sd360 <<< FRAC_BITS;
  localparam logic signed [31:0] SPEED_100 = 32'sd100 <<< FRAC_BITS;

  class pose_scoreboard;
    longint step_size;
    longint x_pos;
    longint y_pos;
    longint head;
    longint atan_q24[24];
    pose_t  pose_queue[$];
    int     mismatches;
    int     drives;
    int     teleports;
    int     clipped;
    int     checked;

    function new();
      atan_q24 = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                   15018523, 7509720, 3754917, 1877466, 938734, 469367,
                   234684, 117342, 58671, 29335, 14668, 7334,
                   3667, 1833, 917, 458, 229, 115};
      step_size = longint'(TIME_STEP_RESET);
      x_pos = 0;
      y_pos = 0;
      head = 0;
    endfunction

    function void set_step(logic [DT_W-1:0] v);
      step_size = longint'(v);
    endfunction

    // round half up: floor((p + 2^(s-1)) / 2^s)
    function longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) begin
        clipped++;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped++;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint wrap_degrees(longint h);
      longint span;
      longint r;
      span = longint'(360) << FRAC_BITS;
      r = h % span;
      if (r < 0) r += span;
      return r;
    endfunction

    // cos/sin in Q2.30 of a heading in [0,360) degrees
    function void rotate(input longint hd, output longint c, output longint s);
      longint full;
      longint half;
      longint quarter;
      longint z;
      longint xa;
      longint ya;
      longint xs;
      longint ys;
      bit     flip;
      full    = longint'(360) << ANG_FRAC;
      half    = longint'(180) << ANG_FRAC;
      quarter = longint'(90) << ANG_FRAC;
      z  = hd << (ANG_FRAC - FRAC_BITS);
      xa = longint'(CORDIC_START);
      ya = 0;
      flip = 1'b0;
      if (z > half) z -= full;
      // fold into [-90,90]; a half-turn fold negates the vector
      if (z > quarter) begin
        z -= half;
        flip = 1'b1;
      end else if (z < -quarter) begin
        z += half;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (z >= 0) begin
          xa -= ys;
          ya += xs;
          z  -= atan_q24[i];
        end else begin
          xa += ys;
          ya -= xs;
          z  += atan_q24[i];
        end
      end
      if (flip) begin
        xa = -xa;
        ya = -ya;
      end
      c = xa;
      s = ya;
    endfunction

    function void note_word(word_op_t op, logic signed [31:0] lin, logic signed [31:0] ang,
                            logic signed [31:0] sx, logic signed [31:0] sy,
                            logic signed [31:0] sh);
      longint c;
      longint s;
      longint v;
      pose_t  p;
      if (op == OP_TELEPORT) begin
        teleports++;
        x_pos = sx;
        y_pos = sy;
        head  = wrap_degrees(longint'(sh));
      end else begin
        drives++;
        head = wrap_degrees(head + round_shift(longint'(ang) * step_size, DT_FRAC));
        rotate(head, c, s);
        v = round_shift(longint'(lin) * c, TRIG_FRAC);
        x_pos = clip32(x_pos + round_shift(v * step_size, DT_FRAC));
        v = round_shift(longint'(lin) * s, TRIG_FRAC);
        y_pos = clip32(y_pos + round_shift(v * step_size, DT_FRAC));
      end
      p.x = x_pos[31:0];
      p.y = y_pos[31:0];
      p.heading = head[HEAD_W-1:0];
      pose_queue.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("unexpected pose word: x %h y %h heading %h", got.x, got.y, got.heading);
        return;
      end
      want = pose_queue.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("pose mismatch #%0d: x exp %h got %h, y exp %h got %h, heading exp %h got %h",
                   checked, want.x, got.x, want.y, got.y, want.heading, got.heading);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [159:0]     s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b1;
  logic [95:0]      m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [DT_W-1:0]  cfg_data = '0;

  bit               quiet = 1'b0;
  bit               stall_on = 1'b1;
  int               ready_hold = 0;
  int unsigned      cycle_count = 0;
  int               idle_cycles = 0;
  int               steps_used = 0;

  pose_scoreboard   pose_sb = new();

  pose_dead_reckoning_integrator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure: random bursts of m_tready low, windows without any
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[6:0] == 0) stall_on <= ($urandom_range(0, 3) != 0);
    if (rst) begin
      m_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) m_tready <= 1'b1;
    end else if (!quiet && stall_on && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      ready_hold <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      pose_sb.check_pose(pose_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[88:64]}));
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("pose_dead_reckoning_integrator_unit verification failed");
    $finish;
  end

  task automatic send_word(word_op_t op, logic signed [31:0] lin, logic signed [31:0] ang,
                           logic signed [31:0] sx, logic signed [31:0] sy,
                           logic signed [31:0] sh);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {sh, sy, sx, ang, lin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pose_sb.note_word(op, lin, ang, sx, sy, sh);
  endtask

  task automatic maybe_pause();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off the sender until every pose has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pose_sb.pose_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(logic [DT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pose_sb.set_step(v);
    steps_used++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2, 3, 4: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: begin
        case ($urandom_range(0, 2))
          0:       return S32_MAX;
          1:       return S32_MIN;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_heading();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 720 << FRAC_BITS);
      2:       return ($signed($urandom_range(0, 16)) - 32'sd8) * DEG_90;
      default: return -$signed($urandom_range(0, 360 << FRAC_BITS));
    endcase
  endfunction

  task automatic send_random();
    word_op_t op;
    op = ($urandom_range(0, 99) < 15) ? OP_TELEPORT : OP_DRIVE;
    send_word(op, pick_value(), pick_value(), pick_value(), pick_value(), pick_heading());
  endtask

  initial begin
    logic [DT_W-1:0] step_pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset time step: zero motion, extreme rates, heading reduction, folds
    send_word(OP_DRIVE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_DRIVE, S32_MAX, S32_MAX, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_DRIVE, S32_MIN, S32_MIN, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_TELEPORT, S32_MAX, S32_MIN, 32'sd1, -32'sd1, -32'sd1);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, S32_MAX, S32_MIN, S32_MAX);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, S32_MIN);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DEG_360);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DEG_90);
    send_word(OP_DRIVE, SPEED_100, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DEG_180);
    send_word(OP_DRIVE, SPEED_100, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DEG_270);
    send_word(OP_DRIVE, SPEED_100, DEG_45, 32'sd0, 32'sd0, 32'sd0);

    // largest step: drive positions into both rails
    drain();
    write_step(16'hFFFF);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sh7FFF_0000, 32'sd0, 32'sd0);
    send_word(OP_DRIVE, S32_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, S32_MIN + 32'sd65536, 32'sd0, DEG_180);
    send_word(OP_DRIVE, S32_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_TELEPORT, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFF_0000, DEG_90);
    send_word(OP_DRIVE, S32_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_DRIVE, S32_MIN, S32_MAX, 32'sd0, 32'sd0, 32'sd0);

    // zero step: drives leave the pose alone
    drain();
    write_step(16'd0);
    send_word(OP_DRIVE, S32_MAX, S32_MAX, 32'sd0, 32'sd0, 32'sd0);
    send_word(OP_DRIVE, pick_value(), pick_value(), 32'sd0, 32'sd0, 32'sd0);

    drain();
    write_step(16'd1);
    send_word(OP_DRIVE, S32_MAX, S32_MIN, 32'sd0, 32'sd0, 32'sd0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0:       step_pick = 16'hFFFF;
        1:       step_pick = $urandom_range(1, 65535);
        2:       step_pick = 16'd1;
        3:       step_pick = TIME_STEP_RESET;
        default: step_pick = $urandom_range(0, 4000);
      endcase
      write_step(step_pick);
      quiet <= (ph == RAND_PHASES - 1);
      repeat (RAND_PER_PHASE) begin
        send_random();
        maybe_pause();
      end
    end
    s_tvalid <= 1'b0;

    while (pose_sb.pose_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d drive and %0d teleport words under %0d time_step writes, %0d clipped",
             pose_sb.drives, pose_sb.teleports, steps_used, pose_sb.clipped);
    $display("      position updates; %0d poses checked, %0d mismatches",
             pose_sb.checked, pose_sb.mismatches);
    if (pose_sb.mismatches == 0 && pose_sb.pose_queue.size() == 0)
      $display("pose_dead_reckoning_integrator_unit verification clean");
    else
      $display("pose_dead_reckoning_integrator_unit verification failed");
    $finish;
  end

endmodule
